FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: src/rri_pkg.sv
`timescale 1ns / 1ps
package rri_pkg;

  localparam int CB        = 20;            // coordinate bits
  localparam int FB        = 10;            // coordinate fraction bits
  localparam int NB        = 20;            // normal component bits
  localparam int DB        = 31;            // distance bits, Q15.16
  localparam int FRAC_T    = 16;            // distance fraction bits
  localparam int SAT_SH    = DB - FRAC_T;
  localparam int CFG_W     = 3 * CB;
  localparam int NRM_W     = 3 * NB;
  localparam int LEN_W     = 2 * CB;
  localparam int MIN_W     = FB;
  localparam int REL_W     = CB + 1;
  localparam int NP_W      = REL_W + NB;
  localparam int NUM_W     = NP_W + 2;
  localparam int DP_W      = CB + NB;
  localparam int DEN_W     = DP_W + 2;
  localparam int REM_W     = DEN_W;
  localparam int PM_W      = DB + 1 + CB;
  localparam int STEP_W    = PM_W - FRAC_T;
  localparam int OP_W      = REL_W + CB;
  localparam int SA_W      = OP_W + 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_W-1:0] CORNER_RST = CFG_W'(64'd1151795604701051904);
  localparam logic [CFG_W-1:0] SIDE_A_RST = CFG_W'(64'd2251799813685248);
  localparam logic [CFG_W-1:0] SIDE_B_RST = CFG_W'(64'd2048);
  localparam logic [NRM_W-1:0] NORMAL_RST = NRM_W'(64'd274877906944);
  localparam logic [LEN_W-1:0] LEN_A_RST  = LEN_W'(64'd4194304);
  localparam logic [LEN_W-1:0] LEN_B_RST  = LEN_W'(64'd4194304);
  localparam logic [MIN_W-1:0] MIN_RST    = MIN_W'(1);
  localparam logic [DB-1:0]    DIST_MAX   = {DB{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORNER,
    CFG_SIDE_A,
    CFG_SIDE_B,
    CFG_NORMAL,
    CFG_LEN_A,
    CFG_LEN_B,
    CFG_MIN_DIST
  } cfg_idx_e;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [NB-1:0] norm_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    norm_t x;
    norm_t y;
    norm_t z;
  } nvec3_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } ray_t;

  typedef struct packed {
    logic          hit_flag;
    logic [DB-1:0] hit_distance;
    coord_t        point_x;
    coord_t        point_y;
    coord_t        point_z;
  } hit_t;

  typedef struct packed {
    vec3_t             corner;
    vec3_t             side_a;
    vec3_t             side_b;
    nvec3_t            normal;
    logic [LEN_W-1:0]  len_a;
    logic [LEN_W-1:0]  len_b;
    logic [MIN_W-1:0]  min_dist;
  } cfg_t;

  typedef struct packed {
    logic             miss;
    logic [NUM_W-1:0] mn;
    logic [DEN_W-1:0] md;
    ray_t             ray;
  } plane_t;

  typedef struct packed {
    logic          miss;
    logic [DB-1:0] t;
    ray_t          ray;
  } tdist_t;

  function automatic vec3_t unpack_vec(logic [CFG_W-1:0] w);
    vec3_t v;
    v.x = w[0 +: CB];
    v.y = w[CB +: CB];
    v.z = w[2*CB +: CB];
    return v;
  endfunction

  function automatic nvec3_t unpack_nrm(logic [NRM_W-1:0] w);
    nvec3_t v;
    v.x = w[0 +: NB];
    v.y = w[NB +: NB];
    v.z = w[2*NB +: NB];
    return v;
  endfunction

endpackage

FILE: src/rri_plane.sv
`timescale 1ns / 1ps
module rri_plane import rri_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  cfg_t   cfg_i,
  input  logic   valid_i,
  input  ray_t   ray_i,
  output logic   valid_o,
  output plane_t data_o
);

  logic [3:0] v_q;

  ray_t ray1_q, ray2_q, ray3_q;
  logic signed [REL_W-1:0] rel_d [3];
  logic signed [REL_W-1:0] rel_q [3];
  logic signed [NP_W-1:0]  np_d [3];
  logic signed [NP_W-1:0]  np_q [3];
  logic signed [DP_W-1:0]  dp_d [3];
  logic signed [DP_W-1:0]  dp_q [3];
  logic signed [NUM_W-1:0] num_d, num_q;
  logic signed [DEN_W-1:0] den_d, den_q;
  plane_t data_d, data_q;

  coord_t c [3];
  coord_t o [3];
  coord_t d [3];
  norm_t  n [3];

  always_comb begin
    c[0] = cfg_i.corner.x;  c[1] = cfg_i.corner.y;  c[2] = cfg_i.corner.z;
    n[0] = cfg_i.normal.x;  n[1] = cfg_i.normal.y;  n[2] = cfg_i.normal.z;
    o[0] = ray_i.origin_x;  o[1] = ray_i.origin_y;  o[2] = ray_i.origin_z;
    d[0] = ray1_q.dir_x;    d[1] = ray1_q.dir_y;    d[2] = ray1_q.dir_z;
    for (int i = 0; i < 3; i++) begin
      rel_d[i] = REL_W'(c[i]) - REL_W'(o[i]);
      np_d[i]  = NP_W'(rel_q[i]) * NP_W'(n[i]);
      dp_d[i]  = DP_W'(d[i]) * DP_W'(n[i]);
    end
    num_d = NUM_W'(np_q[0]) + NUM_W'(np_q[1]) + NUM_W'(np_q[2]);
    den_d = DEN_W'(dp_q[0]) + DEN_W'(dp_q[1]) + DEN_W'(dp_q[2]);
  end

  // parallel ray, ray on the plane, or plane behind the origin
  always_comb begin
    data_d.miss = (den_q == '0) || (num_q == '0) || (num_q[NUM_W-1] != den_q[DEN_W-1]);
    data_d.mn   = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
    data_d.md   = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
    data_d.ray  = ray3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray1_q <= ray_i;
      ray2_q <= ray1_q;
      ray3_q <= ray2_q;
      for (int i = 0; i < 3; i++) begin
        rel_q[i] <= rel_d[i];
        np_q[i]  <= np_d[i];
        dp_q[i]  <= dp_d[i];
      end
      num_q  <= num_d;
      den_q  <= den_d;
      data_q <= data_d;
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = data_q;

endmodule

FILE: src/rri_div.sv
`timescale 1ns / 1ps
module rri_div import rri_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  plane_t data_i,
  output logic   valid_o,
  output tdist_t data_o
);

  typedef struct packed {
    logic             miss;
    logic             sat;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] md;
    logic [DB-1:0]    dbits;
    logic [DB-1:0]    q;
    ray_t             ray;
  } div_t;

  logic [DB:0] v_q;
  div_t stage [DB+1];
  div_t st0_d, st0_q;
  logic [REM_W-1:0] r0;

  // integer part reaching the saturation limit shows up in the top bits alone
  always_comb begin
    r0          = REM_W'(data_i.mn[NUM_W-1:SAT_SH]);
    st0_d.miss  = data_i.miss;
    st0_d.sat   = r0 >= data_i.md;
    st0_d.rem   = st0_d.sat ? '0 : r0;
    st0_d.md    = data_i.md;
    st0_d.dbits = {data_i.mn[SAT_SH-1:0], FRAC_T'(0)};
    st0_d.q     = '0;
    st0_d.ray   = data_i.ray;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st0_q <= st0_d;
    end
  end

  assign stage[0] = st0_q;

  // one restoring quotient bit per stage
  for (genvar k = 0; k < DB; k++) begin : g_step
    logic [REM_W:0] r_sh;
    logic           ge;
    div_t           nxt, cur_q;

    always_comb begin
      nxt       = stage[k];
      r_sh      = {stage[k].rem, stage[k].dbits[DB-1]};
      ge        = r_sh >= {1'b0, stage[k].md};
      nxt.rem   = ge ? REM_W'(r_sh - {1'b0, stage[k].md}) : REM_W'(r_sh);
      nxt.dbits = stage[k].dbits << 1;
      nxt.q     = {stage[k].q[DB-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cur_q <= nxt;
      end
    end

    assign stage[k+1] = cur_q;
  end

  assign valid_o     = v_q[DB];
  assign data_o.miss = stage[DB].miss;
  assign data_o.t    = stage[DB].sat ? DIST_MAX : stage[DB].q;
  assign data_o.ray  = stage[DB].ray;

endmodule

FILE: src/rri_bounds.sv
`timescale 1ns / 1ps
module rri_bounds import rri_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  cfg_t   cfg_i,
  input  logic   valid_i,
  input  tdist_t data_i,
  output logic   valid_o,
  output hit_t   hit_o
);

  localparam int SW = STEP_W + 1;

  logic [4:0] v_q;

  logic          miss1_q, miss2_q, miss3_q, miss4_q, miss1_d;
  logic [DB-1:0] t1_q, t2_q, t3_q, t4_q;

  logic signed [PM_W-1:0]   pm_d [3];
  logic signed [PM_W-1:0]   pm1_q [3];
  coord_t                   o1_q [3];
  logic signed [STEP_W-1:0] step [3];
  logic signed [SW-1:0]     s [3];
  logic                     ovf [3];
  coord_t                   p_d [3];
  coord_t                   p2_q [3];
  coord_t                   p3_q [3];
  coord_t                   p4_q [3];
  logic signed [REL_W-1:0]  off_d [3];
  logic signed [REL_W-1:0]  off3_q [3];
  logic signed [OP_W-1:0]   pa_d [3];
  logic signed [OP_W-1:0]   pb_d [3];
  logic signed [OP_W-1:0]   pa4_q [3];
  logic signed [OP_W-1:0]   pb4_q [3];
  logic signed [SA_W-1:0]   sa, sb;
  logic                     hit;
  hit_t                     hit_d, hit_q;

  coord_t c [3];
  coord_t a [3];
  coord_t b [3];
  coord_t d [3];
  coord_t o [3];

  always_comb begin
    c[0] = cfg_i.corner.x;  c[1] = cfg_i.corner.y;  c[2] = cfg_i.corner.z;
    a[0] = cfg_i.side_a.x;  a[1] = cfg_i.side_a.y;  a[2] = cfg_i.side_a.z;
    b[0] = cfg_i.side_b.x;  b[1] = cfg_i.side_b.y;  b[2] = cfg_i.side_b.z;
    d[0] = data_i.ray.dir_x;    d[1] = data_i.ray.dir_y;    d[2] = data_i.ray.dir_z;
    o[0] = data_i.ray.origin_x; o[1] = data_i.ray.origin_y; o[2] = data_i.ray.origin_z;

    miss1_d = data_i.miss ||
              (data_i.t <= DB'({cfg_i.min_dist, (FRAC_T - FB)'(0)}));

    for (int i = 0; i < 3; i++) begin
      pm_d[i] = PM_W'($signed({1'b0, data_i.t})) * PM_W'(d[i]);
      // floor of t*D to coordinate precision, then clamp
      step[i] = STEP_W'(pm1_q[i] >>> FRAC_T);
      s[i]    = SW'(o1_q[i]) + SW'(step[i]);
      ovf[i]  = !((&s[i][SW-1:CB-1]) || !(|s[i][SW-1:CB-1]));
      p_d[i]  = ovf[i] ? (s[i][SW-1] ? coord_t'({1'b1, {(CB-1){1'b0}}})
                                     : coord_t'({1'b0, {(CB-1){1'b1}}}))
                       : coord_t'(s[i][CB-1:0]);
      off_d[i] = REL_W'(p2_q[i]) - REL_W'(c[i]);
      pa_d[i]  = OP_W'(off3_q[i]) * OP_W'(a[i]);
      pb_d[i]  = OP_W'(off3_q[i]) * OP_W'(b[i]);
    end

    sa = SA_W'(pa4_q[0]) + SA_W'(pa4_q[1]) + SA_W'(pa4_q[2]);
    sb = SA_W'(pb4_q[0]) + SA_W'(pb4_q[1]) + SA_W'(pb4_q[2]);
    hit = !miss4_q &&
          !sa[SA_W-1] && (sa[SA_W-2:0] <= (SA_W-1)'(cfg_i.len_a)) &&
          !sb[SA_W-1] && (sb[SA_W-2:0] <= (SA_W-1)'(cfg_i.len_b));

    hit_d = '0;
    if (hit) begin
      hit_d.hit_flag     = 1'b1;
      hit_d.hit_distance = t4_q;
      hit_d.point_x      = p4_q[0];
      hit_d.point_y      = p4_q[1];
      hit_d.point_z      = p4_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      miss1_q <= miss1_d;
      miss2_q <= miss1_q;
      miss3_q <= miss2_q;
      miss4_q <= miss3_q;
      t1_q    <= data_i.t;
      t2_q    <= t1_q;
      t3_q    <= t2_q;
      t4_q    <= t3_q;
      for (int i = 0; i < 3; i++) begin
        pm1_q[i]  <= pm_d[i];
        o1_q[i]   <= o[i];
        p2_q[i]   <= p_d[i];
        p3_q[i]   <= p2_q[i];
        p4_q[i]   <= p3_q[i];
        off3_q[i] <= off_d[i];
        pa4_q[i]  <= pa_d[i];
        pb4_q[i]  <= pb_d[i];
      end
      hit_q <= hit_d;
    end
  end

  assign valid_o = v_q[4];
  assign hit_o   = hit_q;

endmodule

FILE: src/ray_rectangle_intersection_unit.sv
`timescale 1ns / 1ps
// Ray against rectangle test: one ray request per cycle while the output is not
// stalled, one result per ray. The pipeline holds the 31-bit restoring divider
// for the plane distance, one setup stage plus one quotient bit per pipeline
// stage, plus four stages of plane dot products and five of hit point and
// side tests. The whole pipeline holds while a result waits at the output.
// Misses return all-zero fields. The user must write configuration through the
// cfg port only while no ray is in flight; the block does not enforce this.
`include "assert_macros.svh"
module ray_rectangle_intersection_unit import rri_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ray_t                 in_ray_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hit_t                 out_hit_o
);

  logic [CFG_W-1:0] corner_q, side_a_q, side_b_q;
  logic [NRM_W-1:0] normal_q;
  logic [LEN_W-1:0] len_a_q, len_b_q;
  logic [MIN_W-1:0] min_q;
  cfg_t             cfg;
  logic             en;
  logic             plane_valid, div_valid;
  plane_t           plane_data;
  tdist_t           div_data;
  logic [DB-1:0]    min_dist_t;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= CORNER_RST;
      side_a_q <= SIDE_A_RST;
      side_b_q <= SIDE_B_RST;
      normal_q <= NORMAL_RST;
      len_a_q  <= LEN_A_RST;
      len_b_q  <= LEN_B_RST;
      min_q    <= MIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CORNER:   corner_q <= cfg_data_i;
        CFG_SIDE_A:   side_a_q <= cfg_data_i;
        CFG_SIDE_B:   side_b_q <= cfg_data_i;
        CFG_NORMAL:   normal_q <= NRM_W'(cfg_data_i);
        CFG_LEN_A:    len_a_q  <= cfg_data_i[LEN_W-1:0];
        CFG_LEN_B:    len_b_q  <= cfg_data_i[LEN_W-1:0];
        CFG_MIN_DIST: min_q    <= cfg_data_i[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.corner   = unpack_vec(corner_q);
    cfg.side_a   = unpack_vec(side_a_q);
    cfg.side_b   = unpack_vec(side_b_q);
    cfg.normal   = unpack_nrm(normal_q);
    cfg.len_a    = len_a_q;
    cfg.len_b    = len_b_q;
    cfg.min_dist = min_q;
  end

  // the pipeline moves whenever the output slot is free or being taken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rri_plane u_plane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .ray_i   (in_ray_i),
    .valid_o (plane_valid),
    .data_o  (plane_data)
  );

  rri_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (plane_valid),
    .data_i  (plane_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  rri_bounds u_bounds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (div_valid),
    .data_i  (div_data),
    .valid_o (out_valid_o),
    .hit_o   (out_hit_o)
  );

  assign min_dist_t = DB'({min_q, (FRAC_T - FB)'(0)});

  `ASSERT_PROP(a_hit_beyond_min, out_valid_o && out_hit_o.hit_flag |-> out_hit_o.hit_distance > min_dist_t, "hit closer than minimum distance")
  `ASSERT_PROP(a_miss_zero, out_valid_o && !out_hit_o.hit_flag |-> out_hit_o == '0, "miss with nonzero fields")
  `ASSERT_NEVER(a_stall_without_result, !in_ready_o && !out_valid_o, "pipeline stalled with empty output")

endmodule
